// File: sv/bitmap_run_allocator_assert.svh
`ifndef BITMAP_RUN_ALLOCATOR_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_ASSERT_SVH

// check a property on every clock edge outside of reset
`ifndef NO_ASSERTIONS
`define BRA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bitmap_run_allocator: assertion failed");
// check a property on every clock edge, reset included
`define BRA_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("bitmap_run_allocator: assertion failed");
`else
`define BRA_ASSERT(name, prop)
`define BRA_ASSERT_ALWAYS(name, prop)
`endif

`endif

// File: sv/bra_pkg.sv
package bra_pkg;

  localparam int unsigned IDX_W            = 10;
  localparam int unsigned CNT_W            = 11;
  localparam int unsigned POS_W            = 12;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned WORD_BW          = $clog2(WORD_W);
  localparam int unsigned WIDX_W           = POS_W - WORD_BW;
  localparam int unsigned TOTAL_MAX        = (2 ** CNT_W) - 1;
  localparam int unsigned DEFAULT_MAX_BITS = 1024;
  localparam int unsigned RESET_TOTAL      = 1024;
  localparam int unsigned DEFAULT_DEPTH    = DEFAULT_MAX_BITS / WORD_W;

  typedef enum logic [1:0] {
    FN_QUERY = 2'd0,
    FN_MARK  = 2'd1,
    FN_ALLOC = 2'd2,
    FN_FREE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_RANGE  = 2'd1,
    STAT_NOFREE = 2'd2,
    STAT_ZERO   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_SEARCH,
    ST_BITS,
    ST_SET,
    ST_FREE,
    ST_RESP
  } state_e;

endpackage

// File: sv/bra_ram.sv
module bra_ram #(
  parameter int unsigned WIDTH = bra_pkg::WORD_W,
  parameter int unsigned DEPTH = bra_pkg::DEFAULT_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bitmap_run_allocator.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  func_i, index_i, count_i
// out       output     out_valid_o / out_stall_i status_o, bit_value_o, start_index_o,
//                                               free_count_o, allocated_count_o
// cfg       input      cfg_we_i                 cfg_wdata_i (total_bits)
// Query and mark read their map word through the registered RAM read, then respond; a
// request settled by its range or length check goes straight to the response. Free reads
// and rewrites each map word it touches; allocate searches map words in order, scans a
// partly used word one bit a cycle, then sets the run word by word. After reset and after
// each total_bits write a clearing pass of one RAM word a cycle holds in_stall_o high. A
// result waits under out_stall_i while the next transaction is accepted and runs.
module bitmap_run_allocator #(
  parameter int unsigned MAX_BITS = bra_pkg::DEFAULT_MAX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bra_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                func_i,
  input  logic [bra_pkg::IDX_W-1:0] index_i,
  input  logic [bra_pkg::CNT_W-1:0] count_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic                      bit_value_o,
  output logic [bra_pkg::IDX_W-1:0] start_index_o,
  output logic [bra_pkg::CNT_W-1:0] free_count_o,
  output logic [bra_pkg::CNT_W-1:0] allocated_count_o
);

  import bra_pkg::*;

  `include "bitmap_run_allocator_assert.svh"

  localparam int unsigned CAP   = (MAX_BITS < TOTAL_MAX) ? MAX_BITS : TOTAL_MAX;
  localparam int unsigned DEPTH = (CAP + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RST_T = (RESET_TOTAL < CAP) ? RESET_TOTAL : CAP;

  localparam logic [CNT_W-1:0]   CAP_V   = CNT_W'(CAP);
  localparam logic [CNT_W-1:0]   RST_V   = CNT_W'(RST_T);
  localparam logic [WIDX_W-1:0]  LAST_W  = WIDX_W'(DEPTH - 1);
  localparam logic [WORD_BW-1:0] LAST_B  = WORD_BW'(WORD_W - 1);

  function automatic logic [WORD_BW:0] popcnt(logic [WORD_W-1:0] w);
    logic [WORD_BW:0] acc [WORD_W];
    for (int i = 0; i < WORD_W; i++) begin
      acc[i] = {{WORD_BW{1'b0}}, w[i]};
    end
    for (int s = 1; s < WORD_W; s = s * 2) begin
      for (int i = 0; i + s < WORD_W; i = i + 2 * s) begin
        acc[i] = acc[i] + acc[i+s];
      end
    end
    return acc[0];
  endfunction

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [WIDX_W-1:0]  wd_q, wd_d;
  logic               rd_wait_q, rd_wait_d;
  func_e              func_q, func_d;
  logic [POS_W-1:0]   idx_q, idx_d;
  logic [POS_W-1:0]   hi_q, hi_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [WIDX_W-1:0]  last_q, last_d;
  logic [POS_W-1:0]   run_q, run_d;
  logic [WORD_W-1:0]  word_q, word_d;
  logic [WORD_BW-1:0] bit_q, bit_d;
  status_e            status_q, status_d;
  logic               bitv_q, bitv_d;
  logic [POS_W-1:0]   start_q, start_d;

  logic               out_valid_q;
  status_e            out_status_q;
  logic               out_bitv_q;
  logic [IDX_W-1:0]   out_start_q;
  logic [CNT_W-1:0]   out_free_q;
  logic [CNT_W-1:0]   out_used_q;
  logic               load_out;

  logic               ram_we;
  logic [WORD_W-1:0]  ram_wdata;
  logic [WORD_W-1:0]  ram_rdata;

  logic [POS_W-1:0]   in_lo, in_hi, in_hi_m1, total_p, total_m1, cnt_p;
  logic [POS_W-1:0]   wbase, run_w, run_b, bit_pos;
  logic [WORD_W-1:0]  beyond, rmask, eff;
  logic               go_set, advance;
  logic [POS_W-1:0]   set_start, set_end_m1;

  assign in_lo    = POS_W'(index_i);
  assign in_hi    = in_lo + POS_W'(count_i);
  assign in_hi_m1 = in_hi - POS_W'(1);
  assign total_p  = POS_W'(total_q);
  assign total_m1 = total_p - POS_W'(1);
  assign cnt_p    = POS_W'(cnt_q);
  assign wbase    = {wd_q, {WORD_BW{1'b0}}};
  assign run_w    = run_q + POS_W'(WORD_W);
  assign run_b    = word_q[bit_q] ? '0 : run_q + POS_W'(1);
  assign bit_pos  = wbase + POS_W'(bit_q);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      beyond[b] = (wbase + POS_W'(b)) >= total_p;
      rmask[b]  = ((wbase + POS_W'(b)) >= idx_q) && ((wbase + POS_W'(b)) < hi_q);
    end
  end

  assign eff = ram_rdata | beyond;

  bra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wd_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (wd_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    used_d     = used_q;
    wd_d       = wd_q;
    rd_wait_d  = rd_wait_q;
    func_d     = func_q;
    idx_d      = idx_q;
    hi_d       = hi_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    run_d      = run_q;
    word_d     = word_q;
    bit_d      = bit_q;
    status_d   = status_q;
    bitv_d     = bitv_q;
    start_d    = start_q;
    ram_we     = 1'b0;
    ram_wdata  = ram_rdata;
    load_out   = 1'b0;
    go_set     = 1'b0;
    advance    = 1'b0;
    set_start  = '0;
    set_end_m1 = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (wd_q == LAST_W) begin
          state_d = ST_IDLE;
        end else begin
          wd_d = wd_q + WIDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_e'(func_i);
          idx_d     = in_lo;
          hi_d      = in_hi;
          cnt_d     = count_i;
          status_d  = STAT_OK;
          bitv_d    = 1'b0;
          start_d   = '0;
          run_d     = '0;
          rd_wait_d = 1'b1;
          case (func_e'(func_i))
            FN_QUERY, FN_MARK: begin
              if (CNT_W'(index_i) >= total_q) begin
                status_d = STAT_RANGE;
                state_d  = ST_RESP;
              end else begin
                wd_d    = in_lo[POS_W-1:WORD_BW];
                state_d = ST_QUERY;
              end
            end
            FN_ALLOC: begin
              if (count_i == '0) begin
                status_d = STAT_ZERO;
                state_d  = ST_RESP;
              end else if (count_i > (total_q - used_q)) begin
                status_d = STAT_NOFREE;
                state_d  = ST_RESP;
              end else begin
                wd_d    = '0;
                last_d  = total_m1[POS_W-1:WORD_BW];
                state_d = ST_SEARCH;
              end
            end
            default: begin
              if (count_i == '0) begin
                state_d = ST_RESP;
              end else if (in_hi > total_p) begin
                status_d = STAT_RANGE;
                state_d  = ST_RESP;
              end else begin
                wd_d    = in_lo[POS_W-1:WORD_BW];
                last_d  = in_hi_m1[POS_W-1:WORD_BW];
                state_d = ST_FREE;
              end
            end
          endcase
        end
      end
      ST_QUERY: begin
        if (rd_wait_q) begin
          rd_wait_d = 1'b0;
        end else begin
          if (func_q == FN_MARK) begin
            if (!ram_rdata[idx_q[WORD_BW-1:0]]) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | (WORD_W'(1) << idx_q[WORD_BW-1:0]);
              used_d    = used_q + CNT_W'(1);
            end
          end else begin
            bitv_d = ram_rdata[idx_q[WORD_BW-1:0]];
          end
          state_d = ST_RESP;
        end
      end
      ST_SEARCH: begin
        if (rd_wait_q) begin
          rd_wait_d = 1'b0;
        end else if (eff == '0) begin
          if (run_w >= cnt_p) begin
            go_set    = 1'b1;
            set_start = wbase - run_q;
          end else begin
            run_d   = run_w;
            advance = 1'b1;
          end
        end else if (&eff) begin
          run_d   = '0;
          advance = 1'b1;
        end else begin
          word_d  = eff;
          bit_d   = '0;
          state_d = ST_BITS;
        end
      end
      ST_BITS: begin
        run_d = run_b;
        if (run_b == cnt_p) begin
          go_set    = 1'b1;
          set_start = bit_pos + POS_W'(1) - cnt_p;
        end else if (bit_q == LAST_B) begin
          advance = 1'b1;
        end else begin
          bit_d = bit_q + WORD_BW'(1);
        end
      end
      ST_SET: begin
        if (rd_wait_q) begin
          rd_wait_d = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | rmask;
          if (wd_q == last_q) begin
            used_d  = used_q + cnt_q;
            state_d = ST_RESP;
          end else begin
            wd_d      = wd_q + WIDX_W'(1);
            rd_wait_d = 1'b1;
          end
        end
      end
      ST_FREE: begin
        if (rd_wait_q) begin
          rd_wait_d = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~rmask;
          used_d    = used_q - CNT_W'(popcnt(ram_rdata & rmask));
          if (wd_q == last_q) begin
            state_d = ST_RESP;
          end else begin
            wd_d      = wd_q + WIDX_W'(1);
            rd_wait_d = 1'b1;
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        wd_d    = '0;
      end
    endcase

    if (advance) begin
      if (wd_q == last_q) begin
        status_d = STAT_NOFREE;
        state_d  = ST_RESP;
      end else begin
        wd_d      = wd_q + WIDX_W'(1);
        rd_wait_d = 1'b1;
        state_d   = ST_SEARCH;
      end
    end

    set_end_m1 = set_start + cnt_p - POS_W'(1);
    if (go_set) begin
      start_d   = set_start;
      idx_d     = set_start;
      hi_d      = set_start + cnt_p;
      wd_d      = set_start[POS_W-1:WORD_BW];
      last_d    = set_end_m1[POS_W-1:WORD_BW];
      rd_wait_d = 1'b1;
      state_d   = ST_SET;
    end

    if (cfg_we_i) begin
      total_d = (cfg_wdata_i > CAP_V) ? CAP_V : cfg_wdata_i;
      used_d  = '0;
      wd_d    = '0;
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      total_q     <= RST_V;
      used_q      <= '0;
      wd_q        <= '0;
      rd_wait_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      used_q    <= used_d;
      wd_q      <= wd_d;
      rd_wait_q <= rd_wait_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    idx_q    <= idx_d;
    hi_q     <= hi_d;
    cnt_q    <= cnt_d;
    last_q   <= last_d;
    run_q    <= run_d;
    word_q   <= word_d;
    bit_q    <= bit_d;
    status_q <= status_d;
    bitv_q   <= bitv_d;
    start_q  <= start_d;
    if (load_out) begin
      out_status_q <= status_q;
      out_bitv_q   <= bitv_q;
      out_start_q  <= start_q[IDX_W-1:0];
      out_free_q   <= total_q - used_q;
      out_used_q   <= used_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign bit_value_o       = out_bitv_q;
  assign start_index_o     = out_start_q;
  assign free_count_o      = out_free_q;
  assign allocated_count_o = out_used_q;

  `BRA_ASSERT(a_used_within_total, used_q <= total_q)
  `BRA_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)
  `BRA_ASSERT(a_cfg_clears_count, cfg_we_i |=> (used_q == '0) && (state_q == ST_CLEAR))
  `BRA_ASSERT(a_result_from_resp, $rose(out_valid_q) |-> $past(state_q == ST_RESP))

endmodule
